[rtl/core/ffca_pkg.sv]
// Shared widths, reset values and codes for the first-fit contiguous allocator.
// Used by the allocator top level, its RAM instances' sizing and its port checker.
// Depends on nothing.
package ffca_pkg;

    // Default store sizes
    localparam int LOT_CELLS_DEF  = 1024;
    localparam int MAX_OWNERS_DEF = 16384;

    // Fixed field widths
    localparam int OWNER_W = 14;
    localparam int LEN_W   = 11;
    localparam int START_W = 10;
    localparam int REV_W   = 20;
    localparam int SLEN_W  = 11;

    // Stream data widths (fields rounded up to whole bytes)
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    // Configuration reset and revenue arithmetic
    localparam logic [SLEN_W-1:0] STORE_LEN_RESET = 11'd1024;
    localparam logic [REV_W-1:0]  CHARGE          = 20'd10;
    localparam logic [REV_W-1:0]  REV_MAX         = 20'hFFFFF;

    // Operation codes carried in s_tuser
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

endpackage

[rtl/core/ffca_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; sized by WIDTH and DEPTH parameters.
module ffca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/first_fit_contiguous_allocator.sv]
// An allocate scans cells up to the store length and, if granted, fills the run; a free
// clears the owner's cells from its recorded start; one transaction is handled at a time.
// Throughput is set by the cell-owner RAM scan: one cell read per cycle.
// Reset (aresetn low, synchronous) clears control state, revenue and store length (1024),
// then a clearing pass writes every cell free, with s_tready low.
// Depends on ffca_pkg and ffca_ram.
module first_fit_contiguous_allocator #(
    parameter int LOT_CELLS  = ffca_pkg::LOT_CELLS_DEF,
    parameter int MAX_OWNERS = ffca_pkg::MAX_OWNERS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration: store_length
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ffca_pkg::SLEN_W-1:0]     cfg_data,
    // Requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ffca_pkg::S_TDATA_W-1:0]  s_tdata,  // [13:0] owner_id, [24:14] run_length
    input  logic [0:0]                      s_tuser,  // [0] operation
    // Results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ffca_pkg::M_TDATA_W-1:0]  m_tdata   // [0] granted, [10:1] start_cell,
                                                      // [30:11] revenue_total
);

    localparam int CELL_AW = (LOT_CELLS > 1) ? $clog2(LOT_CELLS) : 1;
    localparam int OWN_AW  = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;
    localparam int LIM_W   = CELL_AW + 1;
    localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(LOT_CELLS - 1);
    localparam logic [LIM_W-1:0]   LOT_LIM   = LIM_W'(LOT_CELLS);

    typedef enum logic [7:0] {
        ST_CLEAR   = 8'b0000_0001,
        ST_IDLE    = 8'b0000_0010,
        ST_A_START = 8'b0000_0100,
        ST_A_SCAN  = 8'b0000_1000,
        ST_A_FILL  = 8'b0001_0000,
        ST_F_RD    = 8'b0010_0000,
        ST_F_SCAN  = 8'b0100_0000,
        ST_REPLY   = 8'b1000_0000
    } state_t;

    state_t                          state_reg, state_next;
    logic [ffca_pkg::SLEN_W-1:0]     slen_reg;
    logic [ffca_pkg::REV_W-1:0]      rev_reg, rev_next;
    logic                            op_reg, op_next;
    logic [ffca_pkg::OWNER_W-1:0]    owner_reg, owner_next;
    logic [ffca_pkg::LEN_W-1:0]      len_reg, len_next;
    logic [CELL_AW-1:0]              cur_reg, cur_next;
    logic [CELL_AW-1:0]              end_reg, end_next;
    logic [ffca_pkg::LEN_W-1:0]      run_reg, run_next;
    logic [LIM_W-1:0]                rstart_reg, rstart_next;
    logic                            gr_reg, gr_next;
    logic [CELL_AW-1:0]              start_reg, start_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [ffca_pkg::M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    // Cell-owner RAM ports
    logic                            cell_we;
    logic [CELL_AW-1:0]              cell_waddr, cell_raddr;
    logic [ffca_pkg::OWNER_W-1:0]    cell_wdata, cell_rdata;
    // Owner-start RAM ports
    logic                            ost_we;
    logic [CELL_AW-1:0]              ost_rdata;

    logic [LIM_W-1:0]                limit;
    logic                            owner_ok;
    logic                            last_cell;
    logic [ffca_pkg::LEN_W-1:0]      run_inc;
    logic [ffca_pkg::REV_W-1:0]      rev_add;

    ffca_ram #(
        .WIDTH (ffca_pkg::OWNER_W),
        .DEPTH (LOT_CELLS)
    ) u_cell_ram (
        .aclk  (aclk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    ffca_ram #(
        .WIDTH (CELL_AW),
        .DEPTH (MAX_OWNERS)
    ) u_start_ram (
        .aclk  (aclk),
        .we    (ost_we),
        .waddr (OWN_AW'(owner_reg)),
        .wdata (CELL_AW'(rstart_reg)),
        .raddr (OWN_AW'(owner_reg)),
        .rdata (ost_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Clip the store length to the lot and qualify the owner
    assign limit     = (32'(slen_reg) >= 32'(LOT_CELLS)) ? LOT_LIM : LIM_W'(slen_reg);
    assign owner_ok  = (owner_reg != '0) && (32'(owner_reg) < 32'(MAX_OWNERS));
    assign last_cell = ((LIM_W'(cur_reg) + LIM_W'(1)) == limit);
    assign run_inc   = run_reg + ffca_pkg::LEN_W'(1);
    assign rev_add   = (rev_reg > (ffca_pkg::REV_MAX - ffca_pkg::CHARGE)) ?
                       ffca_pkg::REV_MAX : (rev_reg + ffca_pkg::CHARGE);

    // Sequencer: clear, scan, fill, release and reply over the cell RAM
    always_comb begin
        state_next    = state_reg;
        rev_next      = rev_reg;
        op_next       = op_reg;
        owner_next    = owner_reg;
        len_next      = len_reg;
        cur_next      = cur_reg;
        end_next      = end_reg;
        run_next      = run_reg;
        rstart_next   = rstart_reg;
        gr_next       = gr_reg;
        start_next    = start_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        cell_we       = 1'b0;
        cell_waddr    = cur_reg;
        cell_wdata    = '0;
        cell_raddr    = cur_reg + CELL_AW'(1);
        ost_we        = 1'b0;

        // Drop the result once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                cell_we  = 1'b1;
                cur_next = cur_reg + CELL_AW'(1);
                if (cur_reg == LAST_CELL) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser[0];
                    owner_next = s_tdata[ffca_pkg::OWNER_W-1:0];
                    len_next   = s_tdata[ffca_pkg::OWNER_W +: ffca_pkg::LEN_W];
                    gr_next    = 1'b0;
                    start_next = '0;
                    state_next = (s_tuser[0] == ffca_pkg::OP_FREE) ? ST_F_RD : ST_A_START;
                end
            end
            ST_A_START: begin
                // Refuse bad owners, empty runs and an empty store; else read cell 0
                cell_raddr  = '0;
                cur_next    = '0;
                run_next    = '0;
                rstart_next = '0;
                if (!owner_ok || len_reg == '0 || limit == '0) begin
                    state_next = ST_REPLY;
                end else begin
                    state_next = ST_A_SCAN;
                end
            end
            ST_A_SCAN: begin
                // Count the free run ending at cur_reg
                cur_next = cur_reg + CELL_AW'(1);
                if (cell_rdata != '0) begin
                    run_next    = '0;
                    rstart_next = LIM_W'(cur_reg) + LIM_W'(1);
                    if (last_cell) begin
                        state_next = ST_REPLY;
                    end
                end else if (run_inc == len_reg) begin
                    ost_we     = 1'b1;
                    end_next   = cur_reg;
                    cur_next   = CELL_AW'(rstart_reg);
                    start_next = CELL_AW'(rstart_reg);
                    state_next = ST_A_FILL;
                end else begin
                    run_next = run_inc;
                    if (last_cell) begin
                        state_next = ST_REPLY;
                    end
                end
            end
            ST_A_FILL: begin
                cell_we    = 1'b1;
                cell_wdata = owner_reg;
                cur_next   = cur_reg + CELL_AW'(1);
                if (cur_reg == end_reg) begin
                    gr_next    = 1'b1;
                    rev_next   = rev_add;
                    state_next = ST_REPLY;
                end
            end
            ST_F_RD: begin
                // Owner start arrives next cycle; invalid owners free nothing
                state_next = owner_ok ? ST_F_SCAN : ST_REPLY;
                cur_next   = '0;
                end_next   = '0;
            end
            ST_F_SCAN: begin
                // First cycle issues the read at the recorded start
                if (end_reg == '0) begin
                    end_next   = '1;
                    cell_raddr = ost_rdata;
                    cur_next   = ost_rdata;
                end else if (cell_rdata == owner_reg) begin
                    cell_we  = 1'b1;
                    cur_next = cur_reg + CELL_AW'(1);
                    if (cur_reg == LAST_CELL) begin
                        state_next = ST_REPLY;
                    end
                end else begin
                    state_next = ST_REPLY;
                end
            end
            ST_REPLY: begin
                // Load the output register once it is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[0] = gr_reg;
                    m_tdata_next[1 +: ffca_pkg::START_W] = ffca_pkg::START_W'(start_reg);
                    m_tdata_next[1 + ffca_pkg::START_W +: ffca_pkg::REV_W] = rev_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cur_reg      <= '0;
            rev_reg      <= '0;
            slen_reg     <= ffca_pkg::STORE_LEN_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            rev_reg      <= rev_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid) begin
                slen_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        owner_reg   <= owner_next;
        len_reg     <= len_next;
        end_reg     <= end_next;
        run_reg     <= run_next;
        rstart_reg  <= rstart_next;
        gr_reg      <= gr_next;
        start_reg   <= start_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

[rtl/core/ffca_checker.sv]
// Port-level checker for the first-fit contiguous allocator, bound to its top level.
// Depends on ffca_pkg and first_fit_contiguous_allocator.
module ffca_port_checks (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ffca_pkg::M_TDATA_W-1:0] m_tdata
);

    // No result is offered right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // One request in flight: accepting closes the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request accepted while busy");

    // A refused or free result carries start cell zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[ffca_pkg::START_W:1] == '0)
        else $error("start cell set without grant");

    // A grant always leaves revenue above zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |->
        m_tdata[ffca_pkg::START_W + ffca_pkg::REV_W:ffca_pkg::START_W + 1] != '0)
        else $error("granted with zero revenue");

endmodule

bind first_fit_contiguous_allocator ffca_port_checks u_ffca_port_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
